// ===== rtl/core/nqbs_pkg.sv =====
// ---------------------------------------------------------------------------
// nqbs_pkg
// Types, codes and the control store of the N-queens backtrack stepper.
// ---------------------------------------------------------------------------
package nqbs_pkg;

    localparam int COL_W      = 4;
    localparam int KIND_W     = 3;
    localparam int COUNT_W    = 14;
    localparam int PACK_W     = 48;
    localparam int PACK_ROWS  = PACK_W / COL_W;
    localparam int CFG_W      = 4;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 80;
    localparam int M_USER_W   = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRY      = 3'd0,
        KIND_CONFLICT = 3'd1,
        KIND_PLACE    = 3'd2,
        KIND_REMOVE   = 3'd3,
        KIND_SOLUTION = 3'd4,
        KIND_DONE     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_TRY   = 2'd0,
        PH_CHECK = 2'd1,
        PH_POP   = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        UOP_WAIT      = 3'd0,
        UOP_DISPATCH  = 3'd1,
        UOP_TRY       = 3'd2,
        UOP_POP       = 3'd3,
        UOP_SCAN_INIT = 3'd4,
        UOP_SCAN      = 3'd5,
        UOP_DONE      = 3'd6
    } uop_t;

    typedef logic [2:0] upc_t;

    typedef struct packed {
        uop_t op;
        upc_t nxt;
    } uword_t;

    localparam upc_t L_WAIT      = 3'd0;
    localparam upc_t L_DISPATCH  = 3'd1;
    localparam upc_t L_TRY       = 3'd2;
    localparam upc_t L_POP       = 3'd3;
    localparam upc_t L_SCAN_INIT = 3'd4;
    localparam upc_t L_SCAN      = 3'd5;
    localparam upc_t L_DONE      = 3'd6;

    // nxt: jump target; emitting steps return to L_WAIT
    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        case (addr)
            L_WAIT:      w = '{op: UOP_WAIT,      nxt: L_DISPATCH};
            L_DISPATCH:  w = '{op: UOP_DISPATCH,  nxt: L_WAIT};
            L_TRY:       w = '{op: UOP_TRY,       nxt: L_POP};
            L_POP:       w = '{op: UOP_POP,       nxt: L_WAIT};
            L_SCAN_INIT: w = '{op: UOP_SCAN_INIT, nxt: L_SCAN};
            L_SCAN:      w = '{op: UOP_SCAN,      nxt: L_SCAN};
            L_DONE:      w = '{op: UOP_DONE,      nxt: L_WAIT};
            default:     w = '{op: UOP_WAIT,      nxt: L_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/n_queens_backtrack_stepper_top.sv =====
// Flow: an input transfer is taken in the wait step, then a dispatch step picks
//   try, pop, scan or done by phase; a try whose row is out of columns falls to
//   pop, or ends the search at row 0, and a check scans the earlier rows in order.
// No new input is accepted until the event for the last one has been emitted.
// Reset: synchronous active-low; search at row 0, try phase, count cleared,
//   board size 4. Queen store is not cleared.
// ---------------------------------------------------------------------------
// n_queens_backtrack_stepper_top
// Microcoded depth-first N-queens search, one trace event per input transfer.
// ---------------------------------------------------------------------------
module n_queens_backtrack_stepper_top #(
    parameter int MAX_ROWS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [nqbs_pkg::CFG_W-1:0]     cfg_wdata,     // board_size
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nqbs_pkg::S_DATA_W-1:0]  s_tdata,       // [0] restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] event_row, [7:4] event_col, [11:8] attacker_row,
    // [15:12] attacker_col, [63:16] board_packed, [77:64] solution_count
    output logic [nqbs_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [nqbs_pkg::M_USER_W-1:0]  m_tuser        // [2:0] event_kind
);
    import nqbs_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int QAW = $clog2(MAX_ROWS);

    logic [COL_W-1:0]   queen_col_reg [MAX_ROWS];

    upc_t               upc_reg, upc_next;
    phase_t             phase_reg, phase_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [RW-1:0]      col_reg, col_next;
    logic [RW-1:0]      idx_reg, idx_next;
    logic [RW-1:0]      n_reg, n_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               m_valid_reg, m_valid_next;
    kind_t              o_kind_reg, o_kind_next;
    logic [COL_W-1:0]   o_row_reg, o_row_next;
    logic [COL_W-1:0]   o_col_reg, o_col_next;
    logic [COL_W-1:0]   o_arow_reg, o_arow_next;
    logic [COL_W-1:0]   o_acol_reg, o_acol_next;
    logic [PACK_W-1:0]  o_pack_reg, o_pack_next;
    logic [COUNT_W-1:0] o_count_reg, o_count_next;

    uword_t             uw;
    logic               out_free;
    logic [QAW-1:0]     rd_addr;
    logic [COL_W-1:0]   q_rd;
    logic [COL_W-1:0]   cq;
    logic [COL_W-1:0]   dc;
    logic [RW-1:0]      rd;
    logic               attack;
    logic [PACK_W-1:0]  packed_board;
    logic               qc_we;

    logic               emit;
    kind_t              e_kind;
    logic [COL_W-1:0]   e_row, e_col, e_arow, e_acol;
    logic [PACK_W-1:0]  e_pack;

    assign uw       = ucode_rom(upc_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (uw.op == UOP_WAIT);

    assign rd_addr = (uw.op == UOP_POP) ? QAW'(row_reg - 1'b1) : QAW'(idx_reg);
    assign q_rd    = queen_col_reg[rd_addr];
    assign cq      = COL_W'(col_reg);
    assign dc      = (q_rd > cq) ? (q_rd - cq) : (cq - q_rd);
    assign rd      = row_reg - idx_reg;
    assign attack  = (q_rd == cq) || (5'(dc) == 5'(rd));

    always_comb begin
        packed_board = '0;
        for (int i = 0; i < PACK_ROWS; i++) begin
            if ((i < MAX_ROWS) && (i < int'(n_reg))) begin
                packed_board[COL_W*i +: COL_W] = queen_col_reg[QAW'(i)];
            end
        end
    end

    always_comb begin
        upc_next   = upc_reg;
        phase_next = phase_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        count_next = count_reg;
        qc_we      = 1'b0;
        emit       = 1'b0;
        e_kind     = KIND_DONE;
        e_row      = '0;
        e_col      = '0;
        e_arow     = '0;
        e_acol     = '0;
        e_pack     = '0;

        case (uw.op)
            UOP_WAIT: begin
                if (s_tvalid) begin
                    if (s_tdata[0]) begin
                        row_next   = '0;
                        col_next   = '0;
                        phase_next = PH_TRY;
                        count_next = '0;
                    end
                    upc_next = uw.nxt;
                end
            end
            UOP_DISPATCH: begin
                case (phase_reg)
                    PH_TRY:   upc_next = L_TRY;
                    PH_CHECK: upc_next = L_SCAN_INIT;
                    PH_POP:   upc_next = L_POP;
                    PH_DONE:  upc_next = L_DONE;
                    default:  upc_next = L_DONE;
                endcase
            end
            UOP_TRY: begin
                if (row_reg >= n_reg) begin
                    if (out_free) begin
                        if (count_reg != '1) begin
                            count_next = count_reg + 1'b1;
                        end
                        phase_next = PH_POP;
                        emit       = 1'b1;
                        e_kind     = KIND_SOLUTION;
                        e_pack     = packed_board;
                        upc_next   = L_WAIT;
                    end
                end else if (col_reg < n_reg) begin
                    if (out_free) begin
                        phase_next = PH_CHECK;
                        emit       = 1'b1;
                        e_kind     = KIND_TRY;
                        e_row      = COL_W'(row_reg);
                        e_col      = COL_W'(col_reg);
                        upc_next   = L_WAIT;
                    end
                end else if (row_reg == '0) begin
                    if (out_free) begin
                        phase_next = PH_DONE;
                        emit       = 1'b1;
                        upc_next   = L_WAIT;
                    end
                end else begin
                    upc_next = uw.nxt;
                end
            end
            UOP_POP: begin
                if (out_free) begin
                    if (row_reg == '0) begin
                        phase_next = PH_DONE;
                        emit       = 1'b1;
                    end else begin
                        row_next   = row_reg - 1'b1;
                        col_next   = RW'(q_rd) + 1'b1;
                        phase_next = PH_TRY;
                        emit       = 1'b1;
                        e_kind     = KIND_REMOVE;
                        e_row      = COL_W'(row_reg - 1'b1);
                        e_col      = q_rd;
                    end
                    upc_next = L_WAIT;
                end
            end
            UOP_SCAN_INIT: begin
                idx_next = '0;
                upc_next = uw.nxt;
            end
            UOP_SCAN: begin
                if (idx_reg >= row_reg) begin
                    if (out_free) begin
                        qc_we      = 1'b1;
                        row_next   = row_reg + 1'b1;
                        col_next   = '0;
                        phase_next = PH_TRY;
                        emit       = 1'b1;
                        e_kind     = KIND_PLACE;
                        e_row      = COL_W'(row_reg);
                        e_col      = cq;
                        upc_next   = L_WAIT;
                    end
                end else if (attack) begin
                    if (out_free) begin
                        col_next   = col_reg + 1'b1;
                        phase_next = PH_TRY;
                        emit       = 1'b1;
                        e_kind     = KIND_CONFLICT;
                        e_row      = COL_W'(row_reg);
                        e_col      = cq;
                        e_arow     = COL_W'(idx_reg);
                        e_acol     = q_rd;
                        upc_next   = L_WAIT;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                    upc_next = uw.nxt;
                end
            end
            UOP_DONE: begin
                if (out_free) begin
                    emit     = 1'b1;
                    upc_next = L_WAIT;
                end
            end
            default: begin
                upc_next = L_WAIT;
            end
        endcase

        // board size write: saturate into 1..MAX_ROWS and restart
        if (cfg_we) begin
            if (cfg_wdata == '0) begin
                n_next = RW'(1);
            end else if (32'(cfg_wdata) > MAX_ROWS) begin
                n_next = RW'(MAX_ROWS);
            end else begin
                n_next = RW'(cfg_wdata);
            end
            row_next   = '0;
            col_next   = '0;
            phase_next = PH_TRY;
            count_next = '0;
        end

        m_valid_next = m_valid_reg && !m_tready;
        o_kind_next  = o_kind_reg;
        o_row_next   = o_row_reg;
        o_col_next   = o_col_reg;
        o_arow_next  = o_arow_reg;
        o_acol_next  = o_acol_reg;
        o_pack_next  = o_pack_reg;
        o_count_next = o_count_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            o_kind_next  = e_kind;
            o_row_next   = e_row;
            o_col_next   = e_col;
            o_arow_next  = e_arow;
            o_acol_next  = e_acol;
            o_pack_next  = e_pack;
            o_count_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= L_WAIT;
            phase_reg   <= PH_TRY;
            row_reg     <= '0;
            col_reg     <= '0;
            idx_reg     <= '0;
            n_reg       <= RW'(4);
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            phase_reg   <= phase_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            idx_reg     <= idx_next;
            n_reg       <= n_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_kind_reg  <= o_kind_next;
        o_row_reg   <= o_row_next;
        o_col_reg   <= o_col_next;
        o_arow_reg  <= o_arow_next;
        o_acol_reg  <= o_acol_next;
        o_pack_reg  <= o_pack_next;
        o_count_reg <= o_count_next;
        if (qc_we) begin
            queen_col_reg[QAW'(row_reg)] <= cq;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, o_count_reg, o_pack_reg, o_acol_reg, o_arow_reg,
                       o_col_reg, o_row_reg};
    assign m_tuser  = {5'b00000, o_kind_reg};

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (upc_reg == L_DISPATCH))
        else $error("input transfer not followed by dispatch");

    a_done_at_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE) |-> (row_reg == '0))
        else $error("search ended away from row zero");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= n_reg)
        else $error("current row beyond board size");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == L_SCAN) |-> (idx_reg <= row_reg))
        else $error("scan index past current row");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result overwritten");

endmodule

// ===== sim/n_queens_backtrack_stepper_checker.sv =====
// ---------------------------------------------------------------------------
// n_queens_backtrack_stepper_checker
// Watches the board-size register, the tick stream and the event stream of
// the N-queens stepper. It keeps its own copy of the search, predicts each
// trace event and checks the events field by field, in order.
// ---------------------------------------------------------------------------
module n_queens_backtrack_stepper_checker #(
    parameter int MAX_ROWS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [nqbs_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [nqbs_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [nqbs_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic [nqbs_pkg::M_USER_W-1:0]  m_tuser,
    output int                             errors,
    output int                             pending,
    output int                             checked
);
    import nqbs_pkg::*;

    localparam int COUNT_MAX = 2**COUNT_W - 1;

    typedef struct packed {
        kind_t              kind;
        logic [COL_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [COL_W-1:0]   att_row;
        logic [COL_W-1:0]   att_col;
        logic [PACK_W-1:0]  board;
        logic [COUNT_W-1:0] count;
    } trace_t;

    int               board_size;
    logic [COL_W-1:0] queen_col [MAX_ROWS];
    int               cur_row;
    int               nxt_col;
    phase_t           phase;
    int               solutions;
    trace_t           trace_q[$];

    function automatic void clear_search();
        cur_row   = 0;
        nxt_col   = 0;
        phase     = PH_TRY;
        solutions = 0;
    endfunction

    // one depth-first step of the search
    function automatic trace_t next_event(input bit restart);
        trace_t ev;
        int     n;
        int     r;
        int     c;
        int     q;
        int     dc;
        int     i;
        bit     hit;
        ev  = '0;
        hit = 1'b0;
        n   = (board_size < 1) ? 1 : (board_size > MAX_ROWS) ? MAX_ROWS : board_size;
        if (restart)
            clear_search();
        if (cur_row > n)
            cur_row = n;
        r = cur_row;
        c = nxt_col;
        // row out of columns: back up
        if (phase == PH_TRY && r < n && c >= n)
            phase = PH_POP;
        case (phase)
            PH_TRY: begin
                if (r >= n) begin
                    for (i = 0; i < n && i < PACK_ROWS; i++)
                        ev.board[COL_W*i +: COL_W] = queen_col[i];
                    if (solutions < COUNT_MAX)
                        solutions++;
                    phase   = PH_POP;
                    ev.kind = KIND_SOLUTION;
                end else begin
                    phase   = PH_CHECK;
                    ev.kind = KIND_TRY;
                    ev.row  = COL_W'(r);
                    ev.col  = COL_W'(c);
                end
            end
            PH_POP: begin
                if (r == 0) begin
                    phase   = PH_DONE;
                    ev.kind = KIND_DONE;
                end else begin
                    r       = r - 1;
                    c       = int'(queen_col[r]);
                    cur_row = r;
                    nxt_col = c + 1;
                    phase   = PH_TRY;
                    ev.kind = KIND_REMOVE;
                    ev.row  = COL_W'(r);
                    ev.col  = COL_W'(c);
                end
            end
            PH_CHECK: begin
                // earliest attacker: lowest earlier row sharing the column or a diagonal
                for (i = 0; i < r && !hit; i++) begin
                    q  = int'(queen_col[i]);
                    dc = (q > c) ? q - c : c - q;
                    if (q == c || dc == r - i) begin
                        hit        = 1'b1;
                        ev.att_row = COL_W'(i);
                        ev.att_col = COL_W'(q);
                    end
                end
                ev.row = COL_W'(r);
                ev.col = COL_W'(c);
                phase  = PH_TRY;
                if (hit) begin
                    nxt_col = c + 1;
                    ev.kind = KIND_CONFLICT;
                end else begin
                    queen_col[r] = COL_W'(c);
                    cur_row      = r + 1;
                    nxt_col      = 0;
                    ev.kind      = KIND_PLACE;
                end
            end
            default: ev.kind = KIND_DONE;
        endcase
        ev.count = COUNT_W'(solutions);
        return ev;
    endfunction

    always @(posedge aclk) begin
        trace_t got;
        trace_t want;
        if (!aresetn) begin
            board_size = 4;
            for (int i = 0; i < MAX_ROWS; i++)
                queen_col[i] = '0;
            clear_search();
            trace_q.delete();
            errors  = 0;
            checked = 0;
            pending <= 0;
        end else begin
            if (cfg_we) begin
                board_size = int'(cfg_wdata);
                clear_search();
            end
            if (s_tvalid && s_tready)
                trace_q.push_back(next_event(s_tdata[0]));
            if (m_tvalid && m_tready) begin
                got.kind    = kind_t'(m_tuser[KIND_W-1:0]);
                got.row     = m_tdata[3:0];
                got.col     = m_tdata[7:4];
                got.att_row = m_tdata[11:8];
                got.att_col = m_tdata[15:12];
                got.board   = m_tdata[63:16];
                got.count   = m_tdata[77:64];
                if (trace_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected event kind %0d row %0d col %0d",
                                 got.kind, got.row, got.col);
                end else begin
                    want = trace_q.pop_front();
                    checked++;
                    if (got.kind !== want.kind || got.row !== want.row ||
                        got.col !== want.col || got.att_row !== want.att_row ||
                        got.att_col !== want.att_col || got.board !== want.board ||
                        got.count !== want.count) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("ERROR: event %0d expected kind %0d sq %0d,%0d att %0d,%0d board %h count %0d",
                                     checked, want.kind, want.row, want.col, want.att_row,
                                     want.att_col, want.board, want.count);
                            $display("       got                kind %0d sq %0d,%0d att %0d,%0d board %h count %0d",
                                     got.kind, got.row, got.col, got.att_row,
                                     got.att_col, got.board, got.count);
                        end
                    end
                end
            end
            pending <= trace_q.size();
        end
    end

endmodule

// ===== sim/n_queens_backtrack_stepper_top_tb.sv =====
// ---------------------------------------------------------------------------
// n_queens_backtrack_stepper_top_tb
// Drives search ticks and restarts into the N-queens stepper across many
// board sizes, with random stalls on both streams, a long output hold-off
// and full drains; the checker predicts and compares every trace event.
// ---------------------------------------------------------------------------
module n_queens_backtrack_stepper_top_tb;
    import nqbs_pkg::*;

    localparam int MAX_ROWS    = 12;
    localparam int NUM_TICKS   = 1550;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;

    int errors;
    int pending;
    int checked;

    int cycle_count   = 0;
    int ticks_sent    = 0;
    int restarts_sent = 0;
    int size_writes   = 0;
    bit tx_idle       = 1'b1;
    bit idle_off      = 1'b0;
    int hold_req      = 0;

    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;
    int window     = 0;
    bit rx_quiet   = 1'b0;

    always #5 aclk = ~aclk;

    n_queens_backtrack_stepper_top #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    n_queens_backtrack_stepper_checker #(
        .MAX_ROWS (MAX_ROWS)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d events outstanding", cycle_count, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // event receiver: random stall bursts, quiet windows, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            window = window + 1;
            if (window == 128) begin
                window   = 0;
                rx_quiet = ($urandom_range(0, 2) == 0);
            end
            if (!idle_off && !rx_quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input bit restart);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(restart);
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
        if (restart)
            restarts_sent++;
        if (!idle_off && tx_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 || m_tvalid)
            @(posedge aclk);
    endtask

    task automatic write_board_size(input int size);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(size);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        size_writes++;
    endtask

    initial begin : stimulus
        int first_sizes[14];
        int phase_idx;
        int size;
        int len;
        int pause_at;
        bit noisy;

        first_sizes = '{15, 12, 0, 2, 3, 5, 6, 8, 13, 14, 9, 10, 11, 7};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default 4x4: same-column and diagonal conflicts, places, restart
        repeat (14) send_tick(1'b0);
        send_tick(1'b1);
        wait_drained();
        // 1x1: try, place, solution, remove, then done repeats
        write_board_size(1);
        repeat (6) send_tick(1'b0);
        wait_drained();
        // size zero saturates up to one
        write_board_size(0);
        repeat (3) send_tick(1'b0);

        phase_idx = 0;
        while (ticks_sent < NUM_TICKS) begin
            wait_drained();
            if (phase_idx < 14)
                size = first_sizes[phase_idx];
            else if ($urandom_range(0, 1) == 0)
                size = $urandom_range(0, 6);
            else
                size = $urandom_range(0, 15);
            write_board_size(size);
            noisy    = ($urandom_range(0, 7) == 0);
            tx_idle  = ($urandom_range(0, 3) != 0);
            idle_off = (ticks_sent > NUM_TICKS - 150);
            len      = $urandom_range(40, 160);
            pause_at = $urandom_range(0, len - 1);
            for (int k = 0; k < len && ticks_sent < NUM_TICKS; k++) begin
                if (phase_idx == 1 && k == 10) begin
                    hold_req <= hold_req + 1;
                    tx_idle  = 1'b0;
                end
                if (k == pause_at && !idle_off &&
                    (phase_idx == 2 || $urandom_range(0, 3) == 0))
                    wait_drained();
                if (noisy)
                    send_tick($urandom_range(0, 2) == 0);
                else
                    send_tick($urandom_range(0, 63) == 0);
            end
            phase_idx++;
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Run: %0d ticks (%0d restarts), %0d board-size writes, %0d events checked",
                 ticks_sent, restarts_sent, size_writes, checked);
        $display("Sizes 0..15 incl. saturation, long output hold-off and full drains exercised");
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d events missing", errors, pending);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
